/* src/interval_max_overlap_core_defines.svh */
// Assertion macros shared by the checker of the interval overlap core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef INTERVAL_MAX_OVERLAP_CORE_DEFINES_SVH
`define INTERVAL_MAX_OVERLAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define IMO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/imo_pkg.sv */
// Package of the interval overlap core: widths, event codes, state type, key helper.
// Depends on nothing; used by every module of the core.
package imo_pkg;

    localparam int IMO_MAX_INTERVALS = 256;
    localparam int COORD_W = 32;
    localparam int KEY_W = COORD_W + 1;
    localparam int OUT_W = 9;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END = 1'b1;
    localparam logic [COORD_W-1:0] COORD_BIAS = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_END,
        ST_SORT_INIT,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_SWEEP_RD,
        ST_SWEEP_ACC,
        ST_EMIT
    } imo_state_t;

    // Event key: biased coordinate so unsigned order equals signed order, kind last.
    function automatic logic [KEY_W-1:0] make_key(input logic [COORD_W-1:0] coord,
                                                  input logic kind);
        make_key = {coord ^ COORD_BIAS, kind};
    endfunction

endpackage

/* src/imo_item_if.sv */
// Stream interfaces of the interval overlap core: interval items and results.
// Depends on imo_pkg for field widths.
interface imo_item_if
    import imo_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_coord;
    logic signed [COORD_W-1:0] end_coord;
    logic                      last;

    modport source (output valid, start_coord, end_coord, last, input ready);
    modport sink (input valid, start_coord, end_coord, last, output ready);
endinterface

interface imo_result_if
    import imo_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] max_overlap;

    modport source (output valid, max_overlap, input ready);
    modport sink (input valid, max_overlap, output ready);
endinterface

/* src/interval_max_overlap_core.sv */
// Maximum interval overlap. Each interval transfer is stored as a start and an end event:
// the start event on acceptance, the end event from the load-end state. The transfer
// flagged last starts a bottom-up merge sort between two event memories: ceil(log2(2N))
// passes, each reading every event from memory, then comparing and writing it, with a
// step per merged pair to move on, followed by a sweep that reads and then accumulates
// each event. Every compare waits on a registered memory read. Intervals beyond
// MAX_INTERVALS are dropped. The result sits in an output register, so the next set may
// load while it waits to be taken.
// Depends on imo_pkg, imo_item_if, imo_result_if, imo_ram and imo_engine.
module interval_max_overlap_core
    import imo_pkg::*;
#(
    parameter int MAX_INTERVALS = IMO_MAX_INTERVALS
) (
    input  logic        clk,
    input  logic        rst_n,
    imo_item_if.sink    items,
    imo_result_if.source results
);

    localparam int EW = $clog2(2 * MAX_INTERVALS);

    logic             res_free;
    logic             res_load;
    logic [OUT_W-1:0] res_value;
    logic             we0;
    logic             we1;
    logic [EW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [EW-1:0]    raddr_a;
    logic [EW-1:0]    raddr_b;
    logic [KEY_W-1:0] rdata0_a;
    logic [KEY_W-1:0] rdata0_b;
    logic [KEY_W-1:0] rdata1_a;
    logic [KEY_W-1:0] rdata1_b;
    logic             res_valid_reg;
    logic [OUT_W-1:0] res_data_reg;

    imo_engine #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .EW(EW)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(items.valid),
        .in_ready(items.ready),
        .start_coord(items.start_coord),
        .end_coord(items.end_coord),
        .last(items.last),
        .res_free(res_free),
        .res_load(res_load),
        .res_value(res_value),
        .we0(we0),
        .we1(we1),
        .waddr(waddr),
        .wdata(wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata0_a(rdata0_a),
        .rdata0_b(rdata0_b),
        .rdata1_a(rdata1_a),
        .rdata1_b(rdata1_b)
    );

    imo_ram #(
        .DEPTH(2 * MAX_INTERVALS),
        .AW(EW)
    ) u_ram0 (
        .clk(clk),
        .we(we0),
        .waddr(waddr),
        .wdata(wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata0_a),
        .rdata_b(rdata0_b)
    );

    imo_ram #(
        .DEPTH(2 * MAX_INTERVALS),
        .AW(EW)
    ) u_ram1 (
        .clk(clk),
        .we(we1),
        .waddr(waddr),
        .wdata(wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata1_a),
        .rdata_b(rdata1_b)
    );

    // Output register: free once empty or being taken in this cycle.
    assign res_free = !res_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_value;
        end
    end

    assign results.valid = res_valid_reg;
    assign results.max_overlap = res_data_reg;

endmodule

/* src/imo_ram.sv */
// Event memory: one write port, two registered read ports.
// Depends on imo_pkg for the key width.
module imo_ram
    import imo_pkg::*;
#(
    parameter int DEPTH = 2 * IMO_MAX_INTERVALS,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [KEY_W-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [KEY_W-1:0] rdata_a,
    output logic [KEY_W-1:0] rdata_b
);

    logic [KEY_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* src/imo_engine.sv */
// Load, merge-sort and sweep sequencer of the interval overlap core.
// Depends on imo_pkg; drives two imo_ram instances placed by the top level.
module imo_engine
    import imo_pkg::*;
#(
    parameter int MAX_INTERVALS = IMO_MAX_INTERVALS,
    parameter int EW = $clog2(2 * MAX_INTERVALS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Interval transfers.
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] start_coord,
    input  logic signed [COORD_W-1:0] end_coord,
    input  logic                      last,
    // Result hand-off to the output register.
    input  logic                      res_free,
    output logic                      res_load,
    output logic [OUT_W-1:0]          res_value,
    // Memory ports; memory 0 and memory 1 share addresses and write data.
    output logic                      we0,
    output logic                      we1,
    output logic [EW-1:0]             waddr,
    output logic [KEY_W-1:0]          wdata,
    output logic [EW-1:0]             raddr_a,
    output logic [EW-1:0]             raddr_b,
    input  logic [KEY_W-1:0]          rdata0_a,
    input  logic [KEY_W-1:0]          rdata0_b,
    input  logic [KEY_W-1:0]          rdata1_a,
    input  logic [KEY_W-1:0]          rdata1_b
);

    localparam int ICW = $clog2(MAX_INTERVALS + 1);
    localparam int EVW = EW + 1;
    localparam int AW = EW + 2;
    localparam int RW = ICW + 1;

    imo_state_t state_reg, state_next;
    logic [ICW-1:0]   cnt_reg, cnt_next;
    logic [EVW-1:0]   ev_reg, ev_next;
    logic [AW-1:0]    width_reg, width_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    li_reg, li_next;
    logic [AW-1:0]    ri_reg, ri_next;
    logic [AW-1:0]    oi_reg, oi_next;
    logic             sel_reg, sel_next;
    logic             lastp_reg, lastp_next;
    logic [KEY_W-1:0] ekey_reg, ekey_next;
    logic signed [RW-1:0] run_reg, run_next;
    logic [ICW-1:0]   best_reg, best_next;

    logic             accept;
    logic             full;
    logic [AW-1:0]    ev_ext;
    logic [AW-1:0]    lend;
    logic [AW-1:0]    rend;
    logic [AW-1:0]    pair_end;
    logic             l_ok;
    logic             r_ok;
    logic [KEY_W-1:0] src_a;
    logic [KEY_W-1:0] src_b;
    logic             take_left;
    logic signed [RW-1:0] run_upd;

    assign accept = in_valid && in_ready;
    assign full = (cnt_reg == ICW'(MAX_INTERVALS));
    assign ev_ext = AW'(ev_reg);

    // Bounds of the two runs of the current merge pair, clipped to the event count.
    always_comb
    begin
        lend = ((base_reg + width_reg) < ev_ext) ? (base_reg + width_reg) : ev_ext;
        pair_end = base_reg + (width_reg << 1);
        rend = (pair_end < ev_ext) ? pair_end : ev_ext;
        l_ok = (li_reg < lend);
        r_ok = (ri_reg < rend);
        src_a = sel_reg ? rdata1_a : rdata0_a;
        src_b = sel_reg ? rdata1_b : rdata0_b;
        take_left = l_ok && (!r_ok || (src_a <= src_b));
        run_upd = (src_a[0] == KIND_END) ? (run_reg - RW'(1)) : (run_reg + RW'(1));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        state_next = ST_LOAD_END;
                    end
                    else if (last)
                    begin
                        state_next = ST_SORT_INIT;
                    end
                end
            end
            ST_LOAD_END:  state_next = lastp_reg ? ST_SORT_INIT : ST_IDLE;
            ST_SORT_INIT: state_next = ST_MERGE_RD;
            ST_MERGE_RD:
            begin
                if (!l_ok && !r_ok && (pair_end >= ev_ext) && ((width_reg << 1) >= ev_ext))
                begin
                    state_next = ST_SWEEP_RD;
                end
                else if (l_ok || r_ok)
                begin
                    state_next = ST_MERGE_WR;
                end
            end
            ST_MERGE_WR:  state_next = ST_MERGE_RD;
            ST_SWEEP_RD:  state_next = (oi_reg >= ev_ext) ? ST_EMIT : ST_SWEEP_ACC;
            ST_SWEEP_ACC: state_next = ST_SWEEP_RD;
            ST_EMIT:      state_next = res_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs toward the memories, the input channel and the result register.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        res_load = (state_reg == ST_EMIT) && res_free;
        res_value = OUT_W'(best_reg);
        we0 = 1'b0;
        we1 = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr_a = li_reg[EW-1:0];
        raddr_b = ri_reg[EW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                we0 = accept && !full;
                waddr = EW'({cnt_reg, 1'b0});
                wdata = make_key(start_coord, KIND_START);
            end
            ST_LOAD_END:
            begin
                we0 = 1'b1;
                waddr = EW'({cnt_reg, 1'b1});
                wdata = ekey_reg;
            end
            ST_MERGE_WR:
            begin
                we0 = sel_reg;
                we1 = !sel_reg;
                waddr = oi_reg[EW-1:0];
                wdata = take_left ? src_a : src_b;
            end
            ST_SWEEP_RD:
            begin
                raddr_a = oi_reg[EW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next = cnt_reg;
        ev_next = ev_reg;
        width_next = width_reg;
        base_next = base_reg;
        li_next = li_reg;
        ri_next = ri_reg;
        oi_next = oi_reg;
        sel_next = sel_reg;
        lastp_next = lastp_reg;
        ekey_next = ekey_reg;
        run_next = run_reg;
        best_next = best_reg;
        case (state_reg)
            ST_IDLE:
            begin
                lastp_next = last;
                ekey_next = make_key(end_coord, KIND_END);
            end
            ST_LOAD_END:
            begin
                cnt_next = cnt_reg + ICW'(1);
            end
            ST_SORT_INIT:
            begin
                ev_next = EVW'({cnt_reg, 1'b0});
                width_next = AW'(1);
                base_next = '0;
                li_next = '0;
                ri_next = AW'(1);
                oi_next = '0;
                sel_next = 1'b0;
                run_next = '0;
                best_next = '0;
            end
            ST_MERGE_RD:
            begin
                // Pair exhausted: step to the next pair, or to the next pass.
                if (!l_ok && !r_ok)
                begin
                    if (pair_end >= ev_ext)
                    begin
                        width_next = width_reg << 1;
                        base_next = '0;
                        li_next = '0;
                        ri_next = width_reg << 1;
                        oi_next = '0;
                        sel_next = !sel_reg;
                    end
                    else
                    begin
                        base_next = pair_end;
                        li_next = pair_end;
                        ri_next = pair_end + width_reg;
                    end
                end
            end
            ST_MERGE_WR:
            begin
                oi_next = oi_reg + AW'(1);
                if (take_left)
                begin
                    li_next = li_reg + AW'(1);
                end
                else
                begin
                    ri_next = ri_reg + AW'(1);
                end
            end
            ST_SWEEP_ACC:
            begin
                oi_next = oi_reg + AW'(1);
                run_next = run_upd;
                if (run_upd > $signed({1'b0, best_reg}))
                begin
                    best_next = run_upd[ICW-1:0];
                end
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    cnt_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Working registers, set up before use.
    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
        width_reg <= width_next;
        base_reg <= base_next;
        li_reg <= li_next;
        ri_reg <= ri_next;
        oi_reg <= oi_next;
        sel_reg <= sel_next;
        lastp_reg <= lastp_next;
        ekey_reg <= ekey_next;
        run_reg <= run_next;
        best_reg <= best_next;
    end

endmodule

/* src/imo_checker.sv */
// Port-level checker of the interval overlap core, bound to the top level.
// Depends on imo_pkg and interval_max_overlap_core_defines.svh.
`include "interval_max_overlap_core_defines.svh"

module imo_checker
    import imo_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_last,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] max_overlap
);

    // A stalled result stays offered.
    `IMO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `IMO_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(max_overlap), "result changed while stalled")

    // The closing interval of a set always starts the sort, so input closes.
    `IMO_ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && in_ready && in_last, !in_ready, "input open after last transfer")

    // A new result only appears after the busy phase of a sort and sweep.
    `IMO_ASSERT_NOW(a_res_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready), "result without preceding sweep")

endmodule

bind interval_max_overlap_core imo_checker u_imo_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(items.valid),
    .in_ready(items.ready),
    .in_last(items.last),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .max_overlap(results.max_overlap)
);

/* tb/imo_tb_if.sv */
`timescale 1ns / 100ps
// Testbench copy check: the block's stream interfaces live with the RTL (imo_item_if,
// imo_result_if); this file only holds small shared testbench types. Depends on imo_pkg.
package imo_tb_pkg;
    import imo_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_coord;
        logic signed [COORD_W-1:0] end_coord;
        logic                      last;
    } interval_t;
endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Testbench of interval_max_overlap_core: drives interval sets, predicts the maximum
// overlap of each set by its own sort and sweep, and checks every result transfer.
// Depends on imo_pkg, imo_tb_pkg and the RTL interfaces imo_item_if and imo_result_if.
module testbench;
    import imo_pkg::*;
    import imo_tb_pkg::*;

    localparam int SET_CAP = IMO_MAX_INTERVALS;

    // Predicts the overlap maximum of each set and holds the answers still due.
    class overlap_scoreboard;
        logic [KEY_W-1:0] events_q[$];
        logic [OUT_W-1:0] due_q[$];
        int               mismatches;
        int               checked;
        int               intervals_seen;

        function void note_interval(interval_t iv);
            int               level;
            int               peak;
            logic [KEY_W-1:0] sorted_keys[$];
            logic [KEY_W-1:0] key;
            intervals_seen++;
            // A full store drops the interval but still honors its last flag.
            if (events_q.size() < 2 * SET_CAP)
            begin
                key = {iv.start_coord ^ COORD_BIAS, KIND_START};
                events_q.insert(events_q.size(), key);
                key = {iv.end_coord ^ COORD_BIAS, KIND_END};
                events_q.insert(events_q.size(), key);
            end
            if (!iv.last)
                return;
            sorted_keys = events_q;
            sorted_keys.sort();
            level = 0;
            peak = 0;
            foreach (sorted_keys[i])
            begin
                if (sorted_keys[i][0] == KIND_END)
                    level--;
                else
                    level++;
                if (level > peak)
                    peak = level;
            end
            due_q.insert(due_q.size(), peak[OUT_W-1:0]);
            events_q.delete();
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            checked++;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result transfer, max_overlap=%0d", got);
                return;
            end
            want = due_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: max_overlap expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tb_failed;

    imo_item_if   items ();
    imo_result_if results ();

    interval_max_overlap_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    overlap_scoreboard board;
    int                sets_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #60ms;
        $display("interval_max_overlap_core test failed");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && items.valid && items.ready)
            board.note_interval('{items.start_coord, items.end_coord, items.last});
        if (rst_n && results.valid && results.ready)
            board.check_result(results.max_overlap);
    end

    // Receiver stalls in a pattern of its own, with a calm stretch now and then.
    int stall_phase = 0;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (!rst_n)
            results.ready <= 1'b0;
        else if ((stall_phase / 200) % 3 == 0)
            results.ready <= 1'b1;
        else
            results.ready <= ($urandom_range(0, 3) != 0);
    end

    int burst_left;

    // Drives one interval; gaps between random bursts fall at the falling edge.
    // Valid drops after a burst or a set ends, so nothing is offered twice.
    task automatic send_interval(input interval_t iv);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        items.valid       <= 1'b1;
        items.start_coord <= iv.start_coord;
        items.end_coord   <= iv.end_coord;
        items.last        <= iv.last;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left == 0 || iv.last)
        begin
            items.valid <= 1'b0;
            burst_left = 0;
        end
        if (iv.last)
            sets_sent++;
    endtask

    function automatic logic signed [31:0] pick_coord(int style);
        case (style)
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom();
            2: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_fffe + $urandom_range(0, 1)
                                                    : 32'sh8000_0000 + $urandom_range(0, 1);
            default: return $urandom_range(0, 1000) - 500;
        endcase
    endfunction

    // Random set: mostly ordered intervals, some reversed, coordinates in a randomly picked style.
    task automatic send_random_set(input int count);
        interval_t iv;
        int        style;
        logic signed [31:0] a, b;
        style = $urandom_range(0, 3);
        for (int k = 0; k < count; k++)
        begin
            a = pick_coord(style);
            b = pick_coord(style);
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                iv.start_coord = b;
                iv.end_coord   = a;
            end
            else
            begin
                iv.start_coord = a;
                iv.end_coord   = b;
            end
            iv.last = (k == count - 1);
            send_interval(iv);
        end
    endtask

    task automatic drain_results();
        while (board.due_q.size() != 0)
            @(negedge clk);
    endtask

    int items_total;

    initial
    begin
        board = new();
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.start_coord = '0;
        items.end_coord = '0;
        items.last = 1'b0;
        burst_left = 0;
        sets_sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: single, touching, nested, reversed, extremes.
        send_interval('{32'sd5, 32'sd5, 1'b1});
        send_interval('{32'sd0, 32'sd10, 1'b0});
        send_interval('{32'sd10, 32'sd20, 1'b1});
        send_interval('{-32'sd100, 32'sd100, 1'b0});
        send_interval('{-32'sd50, 32'sd50, 1'b0});
        send_interval('{32'sd0, 32'sd1, 1'b1});
        send_interval('{32'sd9, 32'sd3, 1'b1});
        send_interval('{32'sd9, 32'sd3, 1'b0});
        send_interval('{32'sd20, 32'sd30, 1'b1});
        send_interval('{32'sh8000_0000, 32'sh7fff_ffff, 1'b0});
        send_interval('{32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0});
        send_interval('{32'sh8000_0000, 32'sh8000_0000, 1'b0});
        send_interval('{32'sh7fff_ffff, 32'sh8000_0000, 1'b1});
        send_interval('{32'shffff_ffff, 32'sh5555_aaaa, 1'b1});

        // Hold off until every answer is in.
        drain_results();

        // Full store: 256 identical, then extras that get dropped, last among them.
        for (int k = 0; k < SET_CAP + 3; k++)
            send_interval('{32'sd1, 32'sd2, k == SET_CAP + 2});
        drain_results();

        items_total = 14 + SET_CAP + 3;
        while (items_total < 1100)
        begin
            int n;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            send_random_set(n);
            items_total += n;
        end

        drain_results();
        repeat (200) @(negedge clk);

        $display("Covered %0d intervals in %0d sets; %0d results checked.",
                 board.intervals_seen, sets_sent, board.checked);
        tb_failed = (board.mismatches != 0) || (board.due_q.size() != 0);
        if (!tb_failed)
            $display("interval_max_overlap_core test passed");
        else
            $display("interval_max_overlap_core test failed");
        $finish;
    end
endmodule
